// ===== design/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo slew ramp package
// Shared constants, register indexes, sequencer states and the control and
// status structs that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int NUM_SERVOS_DEF = 4;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int ANGLE_W    = 8;
   localparam int PULSE_W    = 12;
   localparam int RESP_W     = 16;
   localparam int RATE_W     = 17;
   localparam int OPEN_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam int DIV_W = 33;
   localparam int DSR_W = 24;
   localparam int CNT_W = $clog2(DIV_W + 1);

   localparam int PULSE_BASE = 600;
   localparam int MS_PER_S   = 1000;

   localparam logic [RESP_W-1:0]  RESP_RST       = 16'd250;
   localparam logic [RATE_W-1:0]  RATE_RST       = 17'd1000;
   localparam logic [ANGLE_W-1:0] RIGHT_HIGH_RST = 8'd170;
   localparam logic [ANGLE_W-1:0] RIGHT_LOW_RST  = 8'd40;
   localparam logic [ANGLE_W-1:0] MID_FIRST_RST  = 8'd50;
   localparam logic [ANGLE_W-1:0] MID_SECOND_RST = 8'd160;

   localparam logic [CSR_IDX_W-1:0] CSR_RESPONSE_MS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_HIGH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_LOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_FIRST   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_SECOND  = 3'd5;

   localparam logic [1:0] ROLE_FRONT_RIGHT = 2'd0;
   localparam logic [1:0] ROLE_BACK_RIGHT  = 2'd1;
   localparam logic [1:0] ROLE_FRONT_MID   = 2'd2;
   localparam logic [1:0] ROLE_BACK_MID    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DCALC,
      ST_DWAIT,
      ST_SERVO,
      ST_SWAIT,
      ST_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_HOLD,
      ACT_STOP,
      ACT_STEP
   } servo_act_type;

   typedef struct packed {
      logic req_fire;
      logic d_dirty;
      logic div_done;
      logic servo_moving;
      logic servo_at_goal;
      logic last_servo;
      logic rsp_free;
   } seq_status_type;

   typedef struct packed {
      logic          req_ready;
      logic          div_start_d;
      logic          div_start_step;
      logic          d_load;
      servo_act_type act;
      logic          idx_next;
      logic          rsp_load;
   } seq_ctrl_type;

endpackage

// ===== design/ssr_divider.sv =====
// ----------------------------------------------------------------------------
// Servo slew ramp shared divider
// Restoring divider that retires one quotient bit per cycle. The dividend is
// left-aligned so that only num_bits iterations are spent.
// ----------------------------------------------------------------------------
module ssr_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ssr_pkg::CNT_W-1:0]   num_bits,
   input  logic [ssr_pkg::DIV_W-1:0]   dividend,
   input  logic [ssr_pkg::DSR_W-1:0]   divisor,
   output logic                        busy,
   output logic                        done,
   output logic [ssr_pkg::DIV_W-1:0]   quotient
);

   localparam int DW = ssr_pkg::DIV_W;
   localparam int SW = ssr_pkg::DSR_W;
   localparam int CW = ssr_pkg::CNT_W;

   logic [DW-1:0] quo_ff, quo_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [SW:0]   trial;
   logic          ge;
   logic [CW-1:0] align;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign align = CW'(DW) - num_bits;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend << align;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = num_bits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-2:0], ge};
         rem_in = ge ? SW'(trial - {1'b0, dsr_ff}) : trial[SW-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/ssr_seq.sv =====
// ----------------------------------------------------------------------------
// Servo slew ramp sequencer
// Walks one tick through the optional ramp divisor update and the servos in
// turn, starting the shared divider and steering the datapath updates.
// ----------------------------------------------------------------------------
module ssr_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  ssr_pkg::seq_status_type status,
   output ssr_pkg::seq_ctrl_type   ctrl
);

   ssr_pkg::seq_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssr_pkg::ST_IDLE: begin
            if (status.req_fire) begin
               state_in = status.d_dirty ? ssr_pkg::ST_DCALC : ssr_pkg::ST_SERVO;
            end
         end
         ssr_pkg::ST_DCALC: begin
            state_in = ssr_pkg::ST_DWAIT;
         end
         ssr_pkg::ST_DWAIT: begin
            if (status.div_done) begin
               state_in = ssr_pkg::ST_SERVO;
            end
         end
         ssr_pkg::ST_SERVO: begin
            if (status.servo_moving && !status.servo_at_goal) begin
               state_in = ssr_pkg::ST_SWAIT;
            end else if (status.last_servo) begin
               state_in = ssr_pkg::ST_DONE;
            end
         end
         ssr_pkg::ST_SWAIT: begin
            if (status.div_done) begin
               state_in = status.last_servo ? ssr_pkg::ST_DONE : ssr_pkg::ST_SERVO;
            end
         end
         ssr_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ssr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl                = '0;
      ctrl.act            = ssr_pkg::ACT_NONE;
      unique case (state_ff)
         ssr_pkg::ST_IDLE: begin
            ctrl.req_ready = 1'b1;
         end
         ssr_pkg::ST_DCALC: begin
            ctrl.div_start_d = 1'b1;
         end
         ssr_pkg::ST_DWAIT: begin
            ctrl.d_load = status.div_done;
         end
         ssr_pkg::ST_SERVO: begin
            if (!status.servo_moving) begin
               ctrl.act      = ssr_pkg::ACT_HOLD;
               ctrl.idx_next = 1'b1;
            end else if (status.servo_at_goal) begin
               ctrl.act      = ssr_pkg::ACT_STOP;
               ctrl.idx_next = 1'b1;
            end else begin
               ctrl.div_start_step = 1'b1;
            end
         end
         ssr_pkg::ST_SWAIT: begin
            if (status.div_done) begin
               ctrl.act      = ssr_pkg::ACT_STEP;
               ctrl.idx_next = 1'b1;
            end
         end
         ssr_pkg::ST_DONE: begin
            ctrl.rsp_load = status.rsp_free;
         end
         default: begin
            ctrl.act = ssr_pkg::ACT_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/servo_slew_ramp_four_channel.sv =====
// Each tick walks the servos in turn. A stepping servo runs its ramp step through the shared
// bit-serial divider, and a servo that stops or holds does not use the divider. The first
// tick after reset or after a response time or tick rate write also computes the divisor.
// A new tick is taken only in the idle state, once the previous report has been loaded.
// Synchronous reset restores the register defaults and clears all servo state, except that
// every servo's moving flag is set.
// ----------------------------------------------------------------------------
// Four-channel servo slew ramp
// Each tick runs at most one ramp step per servo and loads its new goal from the tick's
// open flags, then reports the held compare values and moving flags.
// ----------------------------------------------------------------------------
module servo_slew_ramp_four_channel #(
   parameter int NUM_SERVOS = ssr_pkg::NUM_SERVOS_DEF,
   parameter int FRAC_BITS  = ssr_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ssr_pkg::OPEN_W-1:0]       req_open_bits,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ssr_pkg::PULSE_W-1:0]      rsp_pulse_front_right,
   output logic [ssr_pkg::PULSE_W-1:0]      rsp_pulse_back_right,
   output logic [ssr_pkg::PULSE_W-1:0]      rsp_pulse_front_mid,
   output logic [ssr_pkg::PULSE_W-1:0]      rsp_pulse_back_mid,
   output logic [ssr_pkg::OPEN_W-1:0]       rsp_moving_bits,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int AW    = ssr_pkg::ANGLE_W;
   localparam int PW    = ssr_pkg::PULSE_W;
   localparam int POS_W = AW + FRAC_BITS;
   localparam int IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
   localparam int CW    = ssr_pkg::CNT_W;
   localparam int DW    = ssr_pkg::DIV_W;
   localparam int SW    = ssr_pkg::DSR_W;

   ssr_pkg::seq_status_type status;
   ssr_pkg::seq_ctrl_type   ctrl;

   logic [ssr_pkg::RESP_W-1:0] resp_ff, resp_in;
   logic [ssr_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic [AW-1:0] right_high_ff, right_high_in;
   logic [AW-1:0] right_low_ff, right_low_in;
   logic [AW-1:0] mid_first_ff, mid_first_in;
   logic [AW-1:0] mid_second_ff, mid_second_in;
   logic          d_dirty_ff, d_dirty_in;
   logic [SW-1:0] d_ff, d_in;

   logic [POS_W-1:0] pos_ff [NUM_SERVOS];
   logic [POS_W-1:0] pos_in [NUM_SERVOS];
   logic [AW-1:0]    start_ff [NUM_SERVOS];
   logic [AW-1:0]    start_in [NUM_SERVOS];
   logic [AW-1:0]    goal_ff [NUM_SERVOS];
   logic [AW-1:0]    goal_in [NUM_SERVOS];
   logic [PW-1:0]    cmp_ff [NUM_SERVOS];
   logic [PW-1:0]    cmp_in [NUM_SERVOS];
   logic [NUM_SERVOS-1:0] moving_ff, moving_in;
   logic [NUM_SERVOS-1:0] mbits_ff, mbits_in;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [ssr_pkg::OPEN_W-1:0] open_ff, open_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_pulse_ff [4];
   logic [PW-1:0] rsp_pulse_in [4];
   logic [3:0]    rsp_mbits_ff, rsp_mbits_in;
   logic [PW-1:0] pulse_src [4];
   logic [3:0]    mbits_src;

   logic          req_fire;
   logic          div_start, div_busy, div_done;
   logic [CW-1:0] div_bits;
   logic [DW-1:0] div_dividend, div_quotient;
   logic [SW-1:0] div_divisor;
   logic [DW-1:0] prod;

   logic [2:0]       idx_ext;
   logic [1:0]       role;
   logic             open_bit;
   logic [AW-1:0]    new_goal;
   logic [POS_W-1:0] cur_pos, mag, pos_up, pos_dn, pos_new;
   logic [POS_W:0]   pos_sum;
   logic [AW-1:0]    cur_goal, cur_start, diff, pos_int;
   logic             up;
   logic [PW-1:0]    pulse_new;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = !ctrl.req_ready;
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_comb begin
      resp_in       = resp_ff;
      rate_in       = rate_ff;
      right_high_in = right_high_ff;
      right_low_in  = right_low_ff;
      mid_first_in  = mid_first_ff;
      mid_second_in = mid_second_ff;
      d_dirty_in    = ctrl.d_load ? 1'b0 : d_dirty_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ssr_pkg::CSR_RESPONSE_MS: begin
               resp_in    = csr_data[ssr_pkg::RESP_W-1:0];
               d_dirty_in = 1'b1;
            end
            ssr_pkg::CSR_TICK_RATE: begin
               rate_in    = csr_data[ssr_pkg::RATE_W-1:0];
               d_dirty_in = 1'b1;
            end
            ssr_pkg::CSR_RIGHT_HIGH: right_high_in = csr_data[AW-1:0];
            ssr_pkg::CSR_RIGHT_LOW:  right_low_in  = csr_data[AW-1:0];
            ssr_pkg::CSR_MID_FIRST:  mid_first_in  = csr_data[AW-1:0];
            ssr_pkg::CSR_MID_SECOND: mid_second_in = csr_data[AW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign prod = DW'(resp_ff) * DW'(rate_ff);
   assign d_in = ctrl.d_load ? ((div_quotient == '0) ? SW'(1) : div_quotient[SW-1:0]) : d_ff;

   // Current servo.
   assign idx_ext   = 3'(idx_ff);
   assign role      = idx_ext[1:0];
   assign open_bit  = open_ff[role];
   assign cur_pos   = pos_ff[idx_ff];
   assign cur_goal  = goal_ff[idx_ff];
   assign cur_start = start_ff[idx_ff];
   assign up        = cur_goal >= cur_start;
   assign diff      = up ? (cur_goal - cur_start) : (cur_start - cur_goal);

   always_comb begin
      unique case (role)
         ssr_pkg::ROLE_FRONT_RIGHT: new_goal = open_bit ? right_high_ff : right_low_ff;
         ssr_pkg::ROLE_BACK_RIGHT:  new_goal = open_bit ? right_low_ff : right_high_ff;
         ssr_pkg::ROLE_FRONT_MID:   new_goal = open_bit ? mid_first_ff : mid_second_ff;
         ssr_pkg::ROLE_BACK_MID:    new_goal = open_bit ? mid_second_ff : mid_first_ff;
         default:                   new_goal = right_low_ff;
      endcase
   end

   assign mag     = div_quotient[POS_W-1:0];
   assign pos_sum = {1'b0, cur_pos} + {1'b0, mag};
   assign pos_up  = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
   assign pos_dn  = (mag > cur_pos) ? '0 : (cur_pos - mag);
   assign pos_new = up ? pos_up : pos_dn;
   assign pos_int = pos_new[POS_W-1 -: AW];
   assign pulse_new = PW'(ssr_pkg::PULSE_BASE) + (PW'(pos_int) << 3) + (PW'(pos_int) << 1);

   // Shared divider operands.
   assign div_start    = ctrl.div_start_d || ctrl.div_start_step;
   assign div_bits     = ctrl.div_start_d ? CW'(DW) : CW'(POS_W);
   assign div_dividend = ctrl.div_start_d ? prod : DW'({diff, {FRAC_BITS{1'b0}}});
   assign div_divisor  = ctrl.div_start_d ? SW'(ssr_pkg::MS_PER_S) : d_ff;

   ssr_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num_bits (div_bits),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Servo state updates.
   always_comb begin
      pos_in    = pos_ff;
      start_in  = start_ff;
      goal_in   = goal_ff;
      cmp_in    = cmp_ff;
      moving_in = moving_ff;
      mbits_in  = mbits_ff;
      unique case (ctrl.act)
         ssr_pkg::ACT_HOLD: begin
            mbits_in[idx_ff]  = 1'b0;
            goal_in[idx_ff]   = new_goal;
            moving_in[idx_ff] = 1'b1;
         end
         ssr_pkg::ACT_STOP: begin
            start_in[idx_ff]  = cur_goal;
            mbits_in[idx_ff]  = 1'b0;
            goal_in[idx_ff]   = new_goal;
            moving_in[idx_ff] = 1'b1;
         end
         ssr_pkg::ACT_STEP: begin
            pos_in[idx_ff]    = pos_new;
            cmp_in[idx_ff]    = pulse_new;
            mbits_in[idx_ff]  = 1'b1;
            goal_in[idx_ff]   = new_goal;
            moving_in[idx_ff] = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctrl.idx_next) begin
         idx_in = status.last_servo ? '0 : (idx_ff + IDX_W'(1));
      end
   end

   assign open_in = req_fire ? req_open_bits : open_ff;

   // Result register.
   for (genvar k = 0; k < 4; k++) begin : g_src
      if (k < NUM_SERVOS) begin : g_live
         assign pulse_src[k] = cmp_ff[k];
         assign mbits_src[k] = mbits_ff[k];
      end else begin : g_none
         assign pulse_src[k] = '0;
         assign mbits_src[k] = 1'b0;
      end
   end

   always_comb begin
      rsp_pulse_in = rsp_pulse_ff;
      rsp_mbits_in = rsp_mbits_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.rsp_load) begin
         rsp_pulse_in = pulse_src;
         rsp_mbits_in = mbits_src;
         rsp_valid_in = 1'b1;
      end
   end

   assign status.req_fire      = req_fire;
   assign status.d_dirty       = d_dirty_ff;
   assign status.div_done      = div_done;
   assign status.servo_moving  = moving_ff[idx_ff];
   assign status.servo_at_goal = (cur_pos[POS_W-1 -: AW] == cur_goal);
   assign status.last_servo    = (idx_ff == IDX_W'(NUM_SERVOS - 1));
   assign status.rsp_free      = !rsp_valid_ff || !rsp_stall;

   ssr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         resp_ff       <= ssr_pkg::RESP_RST;
         rate_ff       <= ssr_pkg::RATE_RST;
         right_high_ff <= ssr_pkg::RIGHT_HIGH_RST;
         right_low_ff  <= ssr_pkg::RIGHT_LOW_RST;
         mid_first_ff  <= ssr_pkg::MID_FIRST_RST;
         mid_second_ff <= ssr_pkg::MID_SECOND_RST;
         d_dirty_ff    <= 1'b1;
         moving_ff     <= '1;
         mbits_ff      <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_SERVOS; i++) begin
            pos_ff[i]   <= '0;
            start_ff[i] <= '0;
            goal_ff[i]  <= '0;
            cmp_ff[i]   <= '0;
         end
      end else begin
         resp_ff       <= resp_in;
         rate_ff       <= rate_in;
         right_high_ff <= right_high_in;
         right_low_ff  <= right_low_in;
         mid_first_ff  <= mid_first_in;
         mid_second_ff <= mid_second_in;
         d_dirty_ff    <= d_dirty_in;
         moving_ff     <= moving_in;
         mbits_ff      <= mbits_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         pos_ff        <= pos_in;
         start_ff      <= start_in;
         goal_ff       <= goal_in;
         cmp_ff        <= cmp_in;
      end
      d_ff         <= d_in;
      open_ff      <= open_in;
      rsp_pulse_ff <= rsp_pulse_in;
      rsp_mbits_ff <= rsp_mbits_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_pulse_front_right = rsp_pulse_ff[0];
   assign rsp_pulse_back_right  = rsp_pulse_ff[1];
   assign rsp_pulse_front_mid   = rsp_pulse_ff[2];
   assign rsp_pulse_back_mid    = rsp_pulse_ff[3];
   assign rsp_moving_bits       = rsp_mbits_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctrl.div_start_step |-> (d_ff != '0) && !d_dirty_ff)
      else $error("ramp step started without a valid divisor");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(NUM_SERVOS - 1))
      else $error("servo index out of range");

   a_load_after_done: assert property (@(posedge clock) disable iff (reset)
      ctrl.act == ssr_pkg::ACT_STEP |-> div_done)
      else $error("ramp step applied without a divider result");

endmodule
